>>> hw/rtl/imusfp_pkg.sv
package imusfp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ANGLE_W  = 16;
	localparam int unsigned LIMIT_W  = 15;
	localparam int unsigned POS_W    = 5;

	localparam logic [BYTE_W-1:0]  SYNC_BYTE   = 8'hAA;
	localparam logic [POS_W-1:0]   FRAME_LEN   = 5'd19;
	localparam logic [POS_W-1:0]   POS_HUNT1   = 5'd0;
	localparam logic [POS_W-1:0]   POS_HUNT2   = 5'd1;
	localparam logic [POS_W-1:0]   SUM_FIRST   = 5'd2;
	localparam logic [POS_W-1:0]   YAW_LO      = 5'd3;
	localparam logic [POS_W-1:0]   YAW_HI      = 5'd4;
	localparam logic [POS_W-1:0]   PITCH_LO    = 5'd5;
	localparam logic [POS_W-1:0]   PITCH_HI    = 5'd6;
	localparam logic [POS_W-1:0]   SUM_LAST    = 5'd16;
	localparam logic [POS_W-1:0]   CHECK_POS   = 5'd18;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd18000;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	function automatic logic within_limit(input angle_t raw, input logic [LIMIT_W-1:0] limit);
		logic [ANGLE_W:0] mag;
		if (raw[ANGLE_W-1]) begin
			mag = {1'b1, {ANGLE_W{1'b0}}} - {1'b0, raw};
		end else begin
			mag = {1'b0, raw};
		end
		return mag <= {{(ANGLE_W + 1 - LIMIT_W){1'b0}}, limit};
	endfunction

endpackage

>>> hw/rtl/imu_serial_frame_parser_top.sv
// Serial frame parser for an inertial sensor link. Each input transfer carries one received
// byte; the block finds 19-byte frames opening with two 0xAA sync bytes, checks the
// modulo-256 sum of bytes 2 to 16 against byte 18, and for each good frame delivers one
// output transfer with the held yaw and pitch in signed hundredths of a degree. An angle
// whose magnitude exceeds angle_limit leaves the held value unchanged and clears its fresh
// flag. A byte is taken every clock cycle, except while the input is held as told below. Each
// byte passes an input register, and the frame logic loads a good frame's result into the
// output register. The output register lets the next bytes enter while a result waits; only
// the checksum byte of a further good frame holds the input until then.
module imu_serial_frame_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [imusfp_pkg::BYTE_W-1:0]       s_axis_tdata,   // rx_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [2*imusfp_pkg::ANGLE_W-1:0]    m_axis_tdata,   // heading_hundredths, pitch_hundredths
	output logic [1:0]                          m_axis_tuser,   // heading_fresh, pitch_fresh
	input  logic                                cfg_we,
	input  logic [imusfp_pkg::LIMIT_W-1:0]      cfg_wdata       // angle_limit
);

	logic                               valid_s1;
	logic [imusfp_pkg::BYTE_W-1:0]      byte_s1;
	logic [imusfp_pkg::LIMIT_W-1:0]     limit_q;
	logic [imusfp_pkg::POS_W-1:0]       pos_q;
	logic [imusfp_pkg::BYTE_W-1:0]      sum_q;
	imusfp_pkg::angle_t                 yaw_q;
	imusfp_pkg::angle_t                 pitch_q;
	imusfp_pkg::angle_t                 held_heading_q;
	imusfp_pkg::angle_t                 held_pitch_q;

	logic                               out_valid_s2;
	imusfp_pkg::angle_t                 heading_s2;
	imusfp_pkg::angle_t                 pitch_s2;
	logic                               heading_fresh_s2;
	logic                               pitch_fresh_s2;

	logic [imusfp_pkg::POS_W-1:0]       pos;
	logic [imusfp_pkg::POS_W-1:0]       pos_next;
	logic [imusfp_pkg::BYTE_W-1:0]      sum_next;
	imusfp_pkg::angle_t                 yaw_next;
	imusfp_pkg::angle_t                 pitch_next;
	logic                               good_frame;
	logic                               yaw_ok;
	logic                               pitch_ok;
	logic                               out_free;
	logic                               advance;

	assign pos      = (pos_q >= imusfp_pkg::FRAME_LEN) ? imusfp_pkg::POS_HUNT1 : pos_q;
	assign yaw_ok   = imusfp_pkg::within_limit(yaw_q, limit_q);
	assign pitch_ok = imusfp_pkg::within_limit(pitch_q, limit_q);

	always_comb begin
		pos_next   = pos + 5'd1;
		sum_next   = sum_q;
		yaw_next   = yaw_q;
		pitch_next = pitch_q;
		good_frame = 1'b0;
		if (pos == imusfp_pkg::POS_HUNT1) begin
			pos_next = (byte_s1 == imusfp_pkg::SYNC_BYTE) ? imusfp_pkg::POS_HUNT2
				: imusfp_pkg::POS_HUNT1;
			sum_next = '0;
		end else if (pos == imusfp_pkg::POS_HUNT2) begin
			pos_next = (byte_s1 == imusfp_pkg::SYNC_BYTE) ? imusfp_pkg::SUM_FIRST
				: imusfp_pkg::POS_HUNT1;
			sum_next = '0;
		end else if (pos == imusfp_pkg::CHECK_POS) begin
			pos_next   = imusfp_pkg::POS_HUNT1;
			sum_next   = '0;
			good_frame = (sum_q == byte_s1);
		end else begin
			if (pos <= imusfp_pkg::SUM_LAST) begin
				sum_next = sum_q + byte_s1;
			end
			if (pos == imusfp_pkg::YAW_LO) begin
				yaw_next[7:0] = byte_s1;
			end else if (pos == imusfp_pkg::YAW_HI) begin
				yaw_next[15:8] = byte_s1;
			end else if (pos == imusfp_pkg::PITCH_LO) begin
				pitch_next[7:0] = byte_s1;
			end else if (pos == imusfp_pkg::PITCH_HI) begin
				pitch_next[15:8] = byte_s1;
			end
		end
	end

	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && (!good_frame || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= imusfp_pkg::LIMIT_RESET;
			pos_q          <= imusfp_pkg::POS_HUNT1;
			sum_q          <= '0;
			yaw_q          <= '0;
			pitch_q        <= '0;
			held_heading_q <= '0;
			held_pitch_q   <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (advance) begin
				pos_q   <= pos_next;
				sum_q   <= sum_next;
				yaw_q   <= yaw_next;
				pitch_q <= pitch_next;
				if (good_frame && yaw_ok) begin
					held_heading_q <= yaw_q;
				end
				if (good_frame && pitch_ok) begin
					held_pitch_q <= pitch_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= advance && good_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && good_frame) begin
			heading_s2       <= yaw_ok ? yaw_q : held_heading_q;
			pitch_s2         <= pitch_ok ? pitch_q : held_pitch_q;
			heading_fresh_s2 <= yaw_ok;
			pitch_fresh_s2   <= pitch_ok;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {pitch_s2, heading_s2};
	assign m_axis_tuser  = {pitch_fresh_s2, heading_fresh_s2};

endmodule

>>> tb/tb_imu_serial_frame_parser_top.sv
`timescale 1ns / 100ps

module tb_imu_serial_frame_parser_top;

	typedef struct {
		imusfp_pkg::angle_t heading;
		logic               heading_fresh;
		imusfp_pkg::angle_t pitch;
		logic               pitch_fresh;
	} attitude_t;

	typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_SYNC, FRAME_CUT} frame_kind_t;

	// Tracks the parser state byte by byte and holds the attitude results still owed.
	class attitude_scoreboard;
		logic [imusfp_pkg::POS_W-1:0]   frame_pos;
		logic [imusfp_pkg::BYTE_W-1:0]  sum;
		imusfp_pkg::angle_t             yaw_bytes;
		imusfp_pkg::angle_t             pitch_bytes;
		imusfp_pkg::angle_t             held_yaw;
		imusfp_pkg::angle_t             held_pitch;
		logic [imusfp_pkg::LIMIT_W-1:0] limit;
		attitude_t                      owed[$];
		int                             mismatches;

		function new();
			frame_pos   = imusfp_pkg::POS_HUNT1;
			sum         = '0;
			yaw_bytes   = '0;
			pitch_bytes = '0;
			held_yaw    = '0;
			held_pitch  = '0;
			limit       = imusfp_pkg::LIMIT_RESET;
			mismatches  = 0;
		endfunction

		function bit angle_ok(imusfp_pkg::angle_t a);
			int m;
			m = a;
			if (m < 0) begin
				m = -m;
			end
			return m <= int'(limit);
		endfunction

		function void take_byte(logic [imusfp_pkg::BYTE_W-1:0] b);
			logic [imusfp_pkg::POS_W-1:0] pos;
			attitude_t                    res;
			pos = (frame_pos >= imusfp_pkg::FRAME_LEN) ? imusfp_pkg::POS_HUNT1 : frame_pos;
			if (pos == imusfp_pkg::POS_HUNT1 || pos == imusfp_pkg::POS_HUNT2) begin
				frame_pos = (b == imusfp_pkg::SYNC_BYTE) ? pos + 1'b1 : imusfp_pkg::POS_HUNT1;
				sum = '0;
				return;
			end
			if (pos <= imusfp_pkg::SUM_LAST) begin
				sum = sum + b;
			end
			case (pos)
				imusfp_pkg::YAW_LO:   yaw_bytes[7:0] = b;
				imusfp_pkg::YAW_HI:   yaw_bytes[15:8] = b;
				imusfp_pkg::PITCH_LO: pitch_bytes[7:0] = b;
				imusfp_pkg::PITCH_HI: pitch_bytes[15:8] = b;
				default:              ;
			endcase
			if (pos != imusfp_pkg::CHECK_POS) begin
				frame_pos = pos + 1'b1;
				return;
			end
			frame_pos = imusfp_pkg::POS_HUNT1;
			if (sum == b) begin
				res.heading_fresh = angle_ok(yaw_bytes);
				res.pitch_fresh   = angle_ok(pitch_bytes);
				if (res.heading_fresh) begin
					held_yaw = yaw_bytes;
				end
				if (res.pitch_fresh) begin
					held_pitch = pitch_bytes;
				end
				res.heading = held_yaw;
				res.pitch   = held_pitch;
				owed.push_back(res);
			end
			sum = '0;
		endfunction

		function void check_attitude(logic [2*imusfp_pkg::ANGLE_W-1:0] data, logic [1:0] flags);
			attitude_t want;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result heading=%0d pitch=%0d flags=%b", $time,
					$signed(data[15:0]), $signed(data[31:16]), flags);
				mismatches++;
				return;
			end
			want = owed.pop_front();
			if (data[15:0] !== want.heading) begin
				$display("%0t: heading expected %0d actual %0d", $time, want.heading,
					$signed(data[15:0]));
				mismatches++;
			end
			if (flags[0] !== want.heading_fresh) begin
				$display("%0t: heading_fresh expected %b actual %b", $time,
					want.heading_fresh, flags[0]);
				mismatches++;
			end
			if (data[31:16] !== want.pitch) begin
				$display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
					$signed(data[31:16]));
				mismatches++;
			end
			if (flags[1] !== want.pitch_fresh) begin
				$display("%0t: pitch_fresh expected %b actual %b", $time,
					want.pitch_fresh, flags[1]);
				mismatches++;
			end
		endfunction
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 s_axis_tvalid = 1'b0;
	logic                                 s_axis_tready;
	logic [imusfp_pkg::BYTE_W-1:0]        s_axis_tdata = '0;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready = 1'b0;
	logic [2*imusfp_pkg::ANGLE_W-1:0]     m_axis_tdata;
	logic [1:0]                           m_axis_tuser;
	logic                                 cfg_we = 1'b0;
	logic [imusfp_pkg::LIMIT_W-1:0]       cfg_wdata = '0;

	attitude_scoreboard tracker = new();
	int burst_left = 0;
	int stall_mode = 0;
	int stall_count = 0;

	imu_serial_frame_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// The receiver switches among four stall habits, picked at random.
	always @(negedge clk) begin
		stall_count <= stall_count + 1;
		if (stall_count % 64 == 0) begin
			stall_mode <= $urandom_range(0, 3);
		end
		case (stall_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= $urandom_range(0, 1);
			2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ((stall_count / 16) % 2 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.check_attitude(m_axis_tdata, m_axis_tuser);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [imusfp_pkg::BYTE_W-1:0] b);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_byte(b);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (tracker.owed.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(input logic [imusfp_pkg::LIMIT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.limit = value;
	endtask

	function automatic imusfp_pkg::angle_t pick_angle();
		int lim;
		lim = tracker.limit;
		case ($urandom_range(0, 9))
			0:       return 16'sh0000;
			1:       return 16'sh7FFF;
			2:       return 16'sh8000;
			3:       return 16'sh8001;
			4:       return 16'(lim);
			5:       return 16'(-lim);
			6:       return 16'(lim + 1);
			7:       return 16'(-lim - 1);
			8:       return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 2 * lim) - lim);
		endcase
	endfunction

	task automatic send_frame(input frame_kind_t kind, input imusfp_pkg::angle_t yaw,
			input imusfp_pkg::angle_t pitch, inout int sent);
		logic [imusfp_pkg::BYTE_W-1:0] bytes[19];
		logic [imusfp_pkg::BYTE_W-1:0] sum;
		int                            count;
		sum = '0;
		foreach (bytes[i]) begin
			bytes[i] = $urandom_range(0, 255);
		end
		bytes[0] = imusfp_pkg::SYNC_BYTE;
		bytes[1] = imusfp_pkg::SYNC_BYTE;
		bytes[3] = yaw[7:0];
		bytes[4] = yaw[15:8];
		bytes[5] = pitch[7:0];
		bytes[6] = pitch[15:8];
		for (int i = imusfp_pkg::SUM_FIRST; i <= imusfp_pkg::SUM_LAST; i++) begin
			sum = sum + bytes[i];
		end
		bytes[18] = sum;
		count = 19;
		case (kind)
			FRAME_BAD_SUM:  bytes[18] = sum + 8'($urandom_range(1, 255));
			FRAME_BAD_SYNC: begin
				do bytes[1] = $urandom_range(0, 255); while (bytes[1] == imusfp_pkg::SYNC_BYTE);
				count = 2;
			end
			FRAME_CUT:      count = $urandom_range(3, 18);
			default:        ;
		endcase
		for (int i = 0; i < count; i++) begin
			send_byte(bytes[i]);
		end
		sent += count;
	endtask

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [imusfp_pkg::LIMIT_W-1:0] limits[6];
		int                             sent;
		int                             pick;
		limits = '{15'd0, 15'd32767, 15'd1, imusfp_pkg::LIMIT_RESET,
			15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767))};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Noise, a broken second sync byte, then a frame with yaw at the limit and
		// the most negative pitch.
		sent = 0;
		send_byte(8'hFF);
		send_byte(imusfp_pkg::SYNC_BYTE);
		send_byte(8'h55);
		send_frame(FRAME_GOOD, 16'sd18000, 16'sh8000, sent);
		settle();

		foreach (limits[p]) begin
			write_limit(limits[p]);
			sent = 0;
			while (sent < 125) begin
				pick = $urandom_range(0, 9);
				if (pick <= 5) begin
					send_frame(FRAME_GOOD, pick_angle(), pick_angle(), sent);
				end else if (pick == 6) begin
					send_frame(FRAME_BAD_SUM, pick_angle(), pick_angle(), sent);
				end else if (pick == 7) begin
					send_frame(FRAME_BAD_SYNC, pick_angle(), pick_angle(), sent);
				end else if (pick == 8) begin
					send_frame(FRAME_CUT, pick_angle(), pick_angle(), sent);
				end else begin
					repeat ($urandom_range(1, 4)) begin
						send_byte(($urandom_range(0, 2) == 0) ? imusfp_pkg::SYNC_BYTE :
							8'($urandom_range(0, 255)));
						sent++;
					end
				end
			end
			settle();
		end

		if (tracker.owed.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, tracker.owed.size());
			tracker.mismatches++;
		end
		if (tracker.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/imusfp_pkg.sv
hw/rtl/imu_serial_frame_parser_top.sv
tb/tb_imu_serial_frame_parser_top.sv
